FILE: rtl/xte_pkg.sv
// Shared types, constants and byte-mapping functions of the XML text escaper.
package xte_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned RUN_IDX_W = 3;

   // Escape class of one request byte
   typedef enum logic [2:0] {
      CLS_PASS,
      CLS_LT,
      CLS_GT,
      CLS_AMP,
      CLS_CTRL
   } cls_type;

   // One classified request, as held in the queue
   typedef struct packed {
      cls_type    cls;
      logic [7:0] text_byte;
   } entry_type;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_LT   = 8'h3c;
   localparam logic [7:0] CH_GT   = 8'h3e;
   localparam logic [7:0] CH_DEL  = 8'h7f;
   localparam logic [7:0] CH_L    = 8'h6c;
   localparam logic [7:0] CH_G    = 8'h67;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_M    = 8'h6d;
   localparam logic [7:0] CH_P    = 8'h70;
   localparam logic [7:0] CH_0    = 8'h30;

   localparam logic [RUN_IDX_W-1:0] IDX_0 = 3'd0;
   localparam logic [RUN_IDX_W-1:0] IDX_1 = 3'd1;
   localparam logic [RUN_IDX_W-1:0] IDX_2 = 3'd2;
   localparam logic [RUN_IDX_W-1:0] IDX_3 = 3'd3;

   // Number of response bytes a class expands to
   function automatic logic [RUN_IDX_W-1:0] run_len(input cls_type cls);
      logic [RUN_IDX_W-1:0] len;
      case (cls)
         CLS_LT:   len = 3'd4;
         CLS_GT:   len = 3'd4;
         CLS_AMP:  len = 3'd5;
         CLS_CTRL: len = 3'd5;
         default:  len = 3'd1;
      endcase
      return len;
   endfunction

   // Lower-case hex digit of one nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CH_0 + {4'd0, nib};
      end else begin
         ch = CH_A + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

   // Byte at position idx of the escaped run
   function automatic logic [7:0] run_char(input cls_type cls, input logic [7:0] b,
                                           input logic [RUN_IDX_W-1:0] idx);
      logic [7:0] ch;
      ch = CH_SEMI;
      if (cls == CLS_PASS) begin
         ch = b;
      end else if (idx == IDX_0) begin
         ch = CH_AMP;
      end else begin
         case (cls)
            CLS_LT: begin
               if (idx == IDX_1) ch = CH_L;
               else if (idx == IDX_2) ch = CH_T;
            end
            CLS_GT: begin
               if (idx == IDX_1) ch = CH_G;
               else if (idx == IDX_2) ch = CH_T;
            end
            CLS_AMP: begin
               if (idx == IDX_1) ch = CH_A;
               else if (idx == IDX_2) ch = CH_M;
               else if (idx == IDX_3) ch = CH_P;
            end
            CLS_CTRL: begin
               if (idx == IDX_1) ch = CH_HASH;
               else if (idx == IDX_2) ch = hex_digit(b[7:4]);
               else if (idx == IDX_3) ch = hex_digit(b[3:0]);
            end
            default: ch = CH_SEMI;
         endcase
      end
      return ch;
   endfunction

endpackage

FILE: rtl/xte_if.sv
// Valid/ready channel interfaces for requests and escaped response bytes.
interface xte_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

interface xte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;

   modport source (output valid, output out_byte, output run_end, input ready);
   modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

FILE: rtl/xml_text_escape_encoder_core.sv
// Top level of the XML text escaper: front end, request queue and back end.
// Usage:
//   req_ch carries one raw text byte per request (valid/ready).
//   rsp_ch carries the escaped bytes, one per transfer, run_end high on the
//   last byte of each request's run. '<', '>' and '&' become named entities,
//   bytes 0..31 and 127 become "&#hh;" with lower-case hex, all others pass.
// Path: a request passes the classify register, then the queue, then the
//   output register before its first response byte is valid.
// Throughput: one response byte per cycle while rsp_ch.ready is high, set by
//   the back end's single output register; a pass-through request yields one
//   byte, an entity request four or five. Requests keep being accepted while a
//   run is emitted until the queue (QueueDepth entries) and front register
//   fill.
// Reset: synchronous, clears the queue, the run counter and all valid flags;
//   the data registers and the queue storage are not cleared.
// Stall: when rsp_ch.ready is low the output byte holds, the back end stops,
//   and back pressure reaches req_ch.ready once the queue and front register are full.
module xml_text_escape_encoder_core #(
   parameter int unsigned QueueDepth = xte_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   xte_req_if.sink     req_ch,
   xte_rsp_if.source   rsp_ch
);
   import xte_pkg::*;

   localparam int unsigned LevelW = $clog2(QueueDepth + 1);

   logic                 push_valid;
   entry_type            push_entry;
   logic                 push_ready;
   logic                 head_valid;
   entry_type            head_entry;
   logic                 head_pop;
   logic [LevelW-1:0]    q_level;
   logic [RUN_IDX_W-1:0] run_idx;

   xte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   xte_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_entry  (head_entry),
      .pop        (head_pop),
      .level      (q_level)
   );

   xte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .rsp_ch     (rsp_ch),
      .run_idx    (run_idx)
   );

   // Queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      q_level <= LevelW'(QueueDepth))
      else $error("request queue overflow");

   // A byte inside a run leaves the run counter mid-run
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.run_end |-> run_idx != '0)
      else $error("run counter out of step with non-final byte");

   // The last byte of a run leaves the run counter at its start
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.run_end |-> run_idx == '0)
      else $error("run counter not rewound after final byte");

   // A run is never popped while the output holds a byte unaccepted
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !head_pop)
      else $error("queue popped under output stall");

endmodule

FILE: rtl/xte_front.sv
// Front end: accepts requests and classifies each byte into its escape class.
module xte_front (
   input  logic                clock,
   input  logic                reset,
   xte_req_if.sink             req_ch,
   output logic                push_valid,
   output xte_pkg::entry_type  push_entry,
   input  logic                push_ready
);
   import xte_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;
   cls_type   cls;
   logic      take;

   // Classify the incoming byte
   always_comb begin
      case (req_ch.text_byte)
         CH_LT:   cls = CLS_LT;
         CH_GT:   cls = CLS_GT;
         CH_AMP:  cls = CLS_AMP;
         default: begin
            if (req_ch.text_byte inside {[8'h00:8'h1f], CH_DEL}) cls = CLS_CTRL;
            else cls = CLS_PASS;
         end
      endcase
   end

   // Accept when the stage is empty or drains this cycle
   assign req_ch.ready = !valid_ff || push_ready;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (take) begin
         valid_in           = 1'b1;
         entry_in.cls       = cls;
         entry_in.text_byte = req_ch.text_byte;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

FILE: rtl/xte_queue.sv
// Short queue of classified requests between the front and back ends.
module xte_queue #(
   parameter int unsigned Depth = xte_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  xte_pkg::entry_type         push_entry,
   output logic                       push_ready,
   output logic                       pop_valid,
   output xte_pkg::entry_type         pop_entry,
   input  logic                       pop,
   output logic [$clog2(Depth+1)-1:0] level
);
   import xte_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] Full = CntW'(Depth);

   entry_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = count_ff != Full;
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign level      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/xte_back.sv
// Back end: expands each queued request into its run of response bytes.
module xte_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  xte_pkg::entry_type                 head_entry,
   output logic                               head_pop,
   xte_rsp_if.source                          rsp_ch,
   output logic [xte_pkg::RUN_IDX_W-1:0]      run_idx
);
   import xte_pkg::*;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [7:0]           out_byte_ff;
   logic [7:0]           out_byte_in;
   logic                 run_end_ff;
   logic                 run_end_in;
   logic [RUN_IDX_W-1:0] idx_ff;
   logic [RUN_IDX_W-1:0] idx_in;
   logic [RUN_IDX_W-1:0] len;
   logic                 load;
   logic                 last;

   assign len  = run_len(head_entry.cls);
   assign last = idx_ff == (len - 1'b1);
   assign load = head_valid && (!rsp_valid_ff || rsp_ch.ready);

   // Load the next byte of the current run into the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      run_end_in   = run_end_ff;
      idx_in       = idx_ff;
      head_pop     = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = run_char(head_entry.cls, head_entry.text_byte, idx_ff);
         run_end_in   = last;
         if (last) begin
            idx_in   = '0;
            head_pop = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      out_byte_ff <= out_byte_in;
      run_end_ff  <= run_end_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;
   assign rsp_ch.run_end  = run_end_ff;
   assign run_idx         = idx_ff;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench of the XML text escaper: escaped-run prediction and byte checks.
`timescale 1ns / 100ps

module testbench;

   // Characters that get a named entity, and the control range limits
   localparam logic [7:0] LT_CHAR    = "<";
   localparam logic [7:0] GT_CHAR    = ">";
   localparam logic [7:0] AMP_CHAR   = "&";
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] DEL_CHAR   = 8'h7f;

   localparam int unsigned RANDOM_ITEMS = 148;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      RX_STREAM,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_mode_type;

   // One escaped byte as it should leave the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
   } escaped_type;

   // One text byte waiting to be sent, with an optional drain hold-off
   typedef struct packed {
      logic [7:0] text_byte;
      logic       wait_drain;
   } text_item_type;

   logic clock;
   logic reset;

   xte_req_if req_ch ();
   xte_rsp_if rsp_ch ();

   xml_text_escape_encoder_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   text_item_type text_queue[$];
   escaped_type   escaped_queue[$];
   int unsigned   mismatch_count = 0;
   int unsigned   idle_cycles = 0;
   logic          req_fired = 1'b0;
   int unsigned   burst_left = 1;
   int unsigned   gap_left = 0;
   rx_mode_type   rx_mode = RX_STREAM;
   int unsigned   rx_span = 0;
   logic [7:0]    rx_phase = 8'd0;

   // Lower-case hex character of one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = "0" + {4'd0, nib};
      end else begin
         ch = "a" + {4'd0, nib} - 8'd10;
      end
      return ch;
   endfunction

   // Append the escaped run of one text byte to the expected bytes
   function automatic void escape_text_byte(input logic [7:0] b);
      logic [39:0] run;
      int unsigned len;
      escaped_type e;
      if (b == LT_CHAR) begin
         run = {"&lt;", 8'h00};
         len = 4;
      end else if (b == GT_CHAR) begin
         run = {"&gt;", 8'h00};
         len = 4;
      end else if (b == AMP_CHAR) begin
         run = "&amp;";
         len = 5;
      end else if (b < SPACE_CHAR || b == DEL_CHAR) begin
         run = {"&#", hex_char(b[7:4]), hex_char(b[3:0]), ";"};
         len = 5;
      end else begin
         run = {b, 32'h0};
         len = 1;
      end
      for (int k = 0; k < len; k++) begin
         e.out_byte = run[39 - 8 * k -: 8];
         e.run_end  = (k == len - 1);
         escaped_queue.push_back(e);
      end
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: bursts with random gaps, held until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fired) begin
         // hold the request until it is taken
      end else if (gap_left != 0) begin
         req_ch.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (text_queue.size() == 0 ||
                   (text_queue[0].wait_drain && escaped_queue.size() != 0)) begin
         req_ch.valid <= 1'b0;
      end else begin
         req_ch.valid     <= 1'b1;
         req_ch.text_byte <= text_queue[0].text_byte;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // Response stall pattern: switch to a random mode each time the span counter runs out
   always @(negedge clock) begin
      rx_phase <= rx_phase + 8'd1;
      if (rx_span == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_span <= $urandom_range(16, 80);
      end else begin
         rx_span <= rx_span - 1;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STREAM:   rsp_ch.ready <= 1'b1;
            RX_LIGHT:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ch.ready <= (rx_phase[2:0] != 3'd5) && (rx_phase[2:0] != 3'd6);
         endcase
      end
   end

   // Monitor: predict on each accepted request, check each accepted response byte
   always @(posedge clock) begin : monitor_blk
      escaped_type want;
      logic        progress;
      progress = 1'b0;
      req_fired <= !reset && req_ch.valid && req_ch.ready;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            escape_text_byte(req_ch.text_byte);
            void'(text_queue.pop_front());
            progress = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            progress = 1'b1;
            if (escaped_queue.size() == 0) begin
               $display("%0t: unexpected response byte: expected none, actual %02h run_end %0b",
                        $time, rsp_ch.out_byte, rsp_ch.run_end);
               mismatch_count++;
            end else begin
               want = escaped_queue.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                           $time, want.out_byte, rsp_ch.out_byte);
                  mismatch_count++;
               end
               if (rsp_ch.run_end !== want.run_end) begin
                  $display("%0t: run_end mismatch: expected %0b, actual %0b",
                           $time, want.run_end, rsp_ch.run_end);
                  mismatch_count++;
               end
            end
         end
         // Watchdog on cycles without any transfer
         if (progress) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("xml_text_escape_encoder_core regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin : stimulus_blk
      logic [7:0]    directed_bytes[$];
      text_item_type item;
      logic [7:0]    b;
      int unsigned   pick;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.text_byte = 8'h00;
      rsp_ch.ready     = 1'b0;

      // Directed: field extremes, every entity, control edges, high bytes
      directed_bytes = '{8'h00, 8'hff, LT_CHAR, GT_CHAR, AMP_CHAR, 8'h1f, SPACE_CHAR,
                         DEL_CHAR, 8'h80, 8'h7e, 8'h0a, 8'h1a, 8'h0f, 8'h10, 8'hc3,
                         AMP_CHAR, AMP_CHAR, 8'h00, LT_CHAR, 8'h41, GT_CHAR, 8'h55,
                         8'haa};
      foreach (directed_bytes[i]) begin
         item.text_byte  = directed_bytes[i];
         item.wait_drain = 1'b0;
         text_queue.push_back(item);
      end

      // Random: mix of plain text, entities, controls and any byte
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            b = 8'($urandom_range(32, 126));
         end else if (pick < 6) begin
            case ($urandom_range(0, 2))
               0:       b = LT_CHAR;
               1:       b = GT_CHAR;
               default: b = AMP_CHAR;
            endcase
         end else if (pick < 8) begin
            b = ($urandom_range(0, 7) == 0) ? DEL_CHAR : 8'($urandom_range(0, 31));
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         item.text_byte  = b;
         // drain fully before the random part and every so often inside it
         item.wait_drain = (n % 60 == 0);
         text_queue.push_back(item);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for all requests taken and all bytes checked, then settle
      while (text_queue.size() != 0 || escaped_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);

      if (mismatch_count == 0) begin
         $display("xml_text_escape_encoder_core regression: pass");
      end else begin
         $display("xml_text_escape_encoder_core regression: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/xte_pkg.sv
rtl/xte_if.sv
rtl/xte_front.sv
rtl/xte_queue.sv
rtl/xte_back.sv
rtl/xml_text_escape_encoder_core.sv
verif/testbench.sv
